/* rtl/checkpoint_record_parser_top_defines.svh */
// Assertion macros for the checkpoint record parser.
`ifndef CHECKPOINT_RECORD_PARSER_TOP_DEFINES_SVH
`define CHECKPOINT_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("checkpoint parser assertion failed");
`define CPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("checkpoint parser assertion failed");
`else
`define CPR_ASSERT(lbl, clk, rstn, prop)
`define CPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/cpr_pkg.sv */
// Shared types and constants of the checkpoint record parser.
package cpr_pkg;

  localparam logic [31:0] CKPT_MAGIC   = 32'h5450_4B43;
  localparam logic [31:0] CKPT_FORMAT  = 32'd1;
  localparam logic [15:0] MAX_ID_RESET = 16'd1024;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_FORMAT  = 4'd1,
    PH_HEIGHT  = 4'd2,
    PH_HASH    = 4'd3,
    PH_ROOT    = 4'd4,
    PH_VERSION = 4'd5,
    PH_COUNT   = 4'd6,
    PH_IDLEN   = 4'd7,
    PH_ID      = 4'd8,
    PH_SIG     = 4'd9,
    PH_DISCARD = 4'd10,
    PH_DONE    = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_OK         = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_FORMAT = 3'd3,
    ST_ID_LONG    = 3'd4,
    ST_TRUNC      = 3'd5,
    ST_TRAILING   = 3'd6
  } status_e;

  // One classified byte, passed from the front to the back.
  typedef struct packed {
    phase_e      kind;
    logic [15:0] pos;
    logic [7:0]  data;
    logic        nv;
    status_e     status;
    logic        done;
  } cpr_item_t;

  function automatic logic is_numeric(phase_e ph);
    case (ph)
      PH_MAGIC, PH_FORMAT, PH_HEIGHT, PH_VERSION, PH_COUNT, PH_IDLEN: is_numeric = 1'b1;
      default: is_numeric = 1'b0;
    endcase
  endfunction

endpackage

/* rtl/cpr_intf.sv */
// Channel interfaces of the checkpoint record parser.
interface cpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_record;
  modport source (output valid, data_byte, end_of_record, input ready);
  modport sink (input valid, data_byte, end_of_record, output ready);
endinterface

interface cpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_id_length;
  modport source (output valid, max_id_length, input ready);
  modport sink (input valid, max_id_length, output ready);
endinterface

interface cpr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [15:0] field_position;
  logic [7:0]  byte_out;
  logic [63:0] number_value;
  logic        number_valid;
  logic [2:0]  parse_status;
  logic        record_done;
  modport source (output valid, field_kind, field_position, byte_out, number_value,
                  number_valid, parse_status, record_done, input ready);
  modport sink (input valid, field_kind, field_position, byte_out, number_value,
                number_valid, parse_status, record_done, output ready);
endinterface

/* rtl/checkpoint_record_parser_top.sv */
// Checkpoint record parser: one result per input byte.
// An accepted byte is written into the queue, then into the result register, and is presented from there.
// Throughput: one byte per cycle while the queue has room, set by the combinational layout step in the front.
// A two-entry queue and the result register let either side stall without a bubble.
// Reset clears parse state and queue; max_id_length returns to 1024. No clearing pass.
module checkpoint_record_parser_top import cpr_pkg::*; #(
  parameter int unsigned HASH_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpr_in_if.sink     in_i,
  cpr_cfg_if.sink    cfg_i,
  cpr_out_if.source  out_o
);

  cpr_item_t front_item, back_item;
  logic      front_valid, fifo_full, fifo_empty, back_pop;

  cpr_front #(
    .HASH_BYTES(HASH_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (~fifo_full)
  );

  cpr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid & ~fifo_full),
    .push_item_i (front_item),
    .full_o      (fifo_full),
    .pop_i       (back_pop),
    .pop_item_o  (back_item),
    .empty_o     (fifo_empty)
  );

  cpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (~fifo_empty),
    .item_ready_o (back_pop),
    .out_o        (out_o)
  );

endmodule

/* rtl/cpr_front.sv */
// Front: accepts request bytes, tracks the record layout and classifies each byte.
`include "checkpoint_record_parser_top_defines.svh"

module cpr_front import cpr_pkg::*; #(
  parameter int unsigned HASH_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpr_in_if.sink     in_i,
  cpr_cfg_if.sink    cfg_i,
  output cpr_item_t  item_o,
  output logic       item_valid_o,
  input  logic       item_ready_i
);

  localparam logic [15:0] HASH_LEN = 16'(HASH_BYTES);

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] sig_q, sig_d;
  logic [15:0] idl_q, idl_d;
  status_e     err_q, err_d;
  logic [15:0] max_id_q;

  logic        in_acc;
  logic [15:0] pos_inc;
  logic [15:0] idl_dec;
  logic [31:0] sig_dec;
  logic [31:0] acc_new;
  logic        finished;
  cpr_item_t   item;

  function automatic logic [15:0] fixed_len(phase_e ph);
    case (ph)
      PH_MAGIC, PH_FORMAT, PH_COUNT, PH_IDLEN: fixed_len = 16'd4;
      PH_HEIGHT:  fixed_len = 16'd8;
      PH_VERSION: fixed_len = 16'd2;
      default:    fixed_len = HASH_LEN;
    endcase
  endfunction

  assign in_i.ready   = item_ready_i;
  assign in_acc       = in_i.valid & item_ready_i;
  assign item_valid_o = in_i.valid;
  assign item_o       = item;
  assign cfg_i.ready  = 1'b1;

  assign pos_inc = pos_q + 16'd1;
  assign idl_dec = idl_q - 16'd1;
  assign sig_dec = sig_q - 32'd1;
  assign acc_new = acc_q | (32'(in_i.data_byte) << {pos_q[1:0], 3'b000});
  assign finished = (phase_q == PH_ID) ? (idl_dec == 16'd0)
                                       : (pos_inc >= fixed_len(phase_q));

  // next state; the end-of-record restart is applied at the register
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    sig_d   = sig_q;
    idl_d   = idl_q;
    err_d   = err_q;

    if (phase_q == PH_DONE) begin
      err_d   = ST_TRAILING;
      phase_d = PH_DISCARD;
    end else if (phase_q != PH_DISCARD) begin
      pos_d = pos_inc;
      if (is_numeric(phase_q)) begin
        acc_d = acc_new;
      end
      if (phase_q == PH_ID) begin
        idl_d = idl_dec;
      end
      if (finished) begin
        pos_d = 16'd0;
        acc_d = 32'd0;
        case (phase_q)
          PH_MAGIC: begin
            if (acc_new != CKPT_MAGIC) begin
              err_d   = ST_BAD_MAGIC;
              phase_d = PH_DISCARD;
            end else begin
              phase_d = PH_FORMAT;
            end
          end
          PH_FORMAT: begin
            if (acc_new != CKPT_FORMAT) begin
              err_d   = ST_BAD_FORMAT;
              phase_d = PH_DISCARD;
            end else begin
              phase_d = PH_HEIGHT;
            end
          end
          PH_HEIGHT:  phase_d = PH_HASH;
          PH_HASH:    phase_d = PH_ROOT;
          PH_ROOT:    phase_d = PH_VERSION;
          PH_VERSION: phase_d = PH_COUNT;
          PH_COUNT: begin
            sig_d   = acc_new;
            phase_d = (acc_new != 32'd0) ? PH_IDLEN : PH_DONE;
          end
          PH_IDLEN: begin
            if (acc_new > {16'd0, max_id_q}) begin
              err_d   = ST_ID_LONG;
              phase_d = PH_DISCARD;
            end else begin
              idl_d   = acc_new[15:0];
              phase_d = (acc_new != 32'd0) ? PH_ID : PH_SIG;
            end
          end
          PH_ID: phase_d = PH_SIG;
          default: begin
            sig_d   = sig_dec;
            phase_d = (sig_dec != 32'd0) ? PH_IDLEN : PH_DONE;
          end
        endcase
      end
    end
  end

  // classified byte
  always_comb begin
    item.kind   = PH_DISCARD;
    item.pos    = 16'd0;
    item.data   = in_i.data_byte;
    item.nv     = 1'b0;
    item.status = ST_BUSY;
    item.done   = in_i.end_of_record;

    if (phase_q != PH_DONE && phase_q != PH_DISCARD) begin
      item.kind = phase_q;
      item.pos  = pos_q;
      item.nv   = finished & is_numeric(phase_q);
    end

    if (err_d != ST_BUSY) begin
      item.status = err_d;
    end else if (in_i.end_of_record) begin
      item.status = (phase_d == PH_DONE) ? ST_OK : ST_TRUNC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      pos_q   <= 16'd0;
      acc_q   <= 32'd0;
      sig_q   <= 32'd0;
      idl_q   <= 16'd0;
      err_q   <= ST_BUSY;
    end else if (in_acc) begin
      if (in_i.end_of_record) begin
        phase_q <= PH_MAGIC;
        pos_q   <= 16'd0;
        acc_q   <= 32'd0;
        sig_q   <= 32'd0;
        idl_q   <= 16'd0;
        err_q   <= ST_BUSY;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        acc_q   <= acc_d;
        sig_q   <= sig_d;
        idl_q   <= idl_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_id_q <= MAX_ID_RESET;
    end else if (cfg_i.valid) begin
      max_id_q <= cfg_i.max_id_length;
    end
  end

  `CPR_ASSERT_NEXT(a_eor_restart, clk_i, rst_ni, in_acc && in_i.end_of_record,
                   phase_q == PH_MAGIC && err_q == ST_BUSY && pos_q == 16'd0)
  `CPR_ASSERT(a_discard_has_err, clk_i, rst_ni, phase_q != PH_DISCARD || err_q != ST_BUSY)
  `CPR_ASSERT(a_id_nonzero, clk_i, rst_ni, phase_q != PH_ID || idl_q != 16'd0)
  `CPR_ASSERT(a_sig_pending, clk_i, rst_ni,
              (phase_q != PH_IDLEN && phase_q != PH_ID && phase_q != PH_SIG) ||
              sig_q != 32'd0)

endmodule

/* rtl/cpr_fifo.sv */
// Two-entry queue of classified bytes between front and back.
module cpr_fifo import cpr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cpr_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output cpr_item_t pop_item_o,
  output logic      empty_o
);

  cpr_item_t   mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/cpr_back.sv */
// Back: assembles numeric field values and drives the registered result channel.
module cpr_back import cpr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpr_item_t item_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  cpr_out_if.source out_o
);

  logic        out_valid_q;
  cpr_item_t   res_q;
  logic [63:0] val_q, val_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] acc_sum;
  logic        pop;

  assign pop          = item_valid_i & (~out_valid_q | out_o.ready);
  assign item_ready_o = pop;

  assign acc_sum = is_numeric(item_i.kind)
                 ? (acc_q | (64'(item_i.data) << {item_i.pos[2:0], 3'b000}))
                 : acc_q;

  always_comb begin
    val_d = 64'd0;
    acc_d = acc_sum;
    if (item_i.nv) begin
      val_d = acc_sum;
      acc_d = 64'd0;
    end
    if (item_i.done) begin
      acc_d = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= 64'd0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= item_i;
      val_q <= val_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.field_kind     = res_q.kind;
  assign out_o.field_position = res_q.pos;
  assign out_o.byte_out       = res_q.data;
  assign out_o.number_value   = val_q;
  assign out_o.number_valid   = res_q.nv;
  assign out_o.parse_status   = res_q.status;
  assign out_o.record_done    = res_q.done;

endmodule

/* verif/tb_checkpoint_record_parser_top.sv */
// Self-checking testbench of the checkpoint record parser: record streams against a predictor.
`timescale 1ns / 100ps

module tb_checkpoint_record_parser_top;
  import cpr_pkg::*;

  localparam int unsigned HASH_LEN = 32;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_BYTES = 60;

  typedef enum logic [2:0] {
    SHAPE_GOOD,
    SHAPE_TRUNC,
    SHAPE_TRAIL,
    SHAPE_BAD_MAGIC,
    SHAPE_BAD_FORMAT,
    SHAPE_ID_LONG,
    SHAPE_NOISE
  } rec_shape_e;

  typedef enum logic [1:0] {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } stream_byte_t;

  typedef struct packed {
    phase_e      kind;
    logic [15:0] pos;
    logic [7:0]  data;
    logic [63:0] value;
    logic        nv;
    status_e     status;
    logic        done;
  } classified_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpr_in_if  in_if();
  cpr_cfg_if cfg_if();
  cpr_out_if out_if();

  checkpoint_record_parser_top #(.HASH_BYTES(HASH_LEN)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser shadow state
  phase_e      parse_ph;
  logic [31:0] field_pos;
  logic [63:0] num_acc;
  logic [31:0] sigs_left;
  logic [31:0] id_left;
  status_e     latched_err;
  logic [15:0] id_limit;

  stream_byte_t record_bytes_q[$];
  classified_t  classified_q[$];
  stream_byte_t next_byte;
  classified_t  want;
  int unsigned  bytes_queued;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  stall_hold;
  int unsigned  fail_count;
  int unsigned  cycle_count;
  logic         in_taken;

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] exp_val);
    fail_count++;
    $display("ERROR @%0t %s: got %0h, want %0h", $time, what, got, exp_val);
  endtask

  function automatic logic carries_number(phase_e ph);
    return ph == PH_MAGIC || ph == PH_FORMAT || ph == PH_HEIGHT ||
           ph == PH_VERSION || ph == PH_COUNT || ph == PH_IDLEN;
  endfunction

  function automatic int unsigned field_len(phase_e ph);
    case (ph)
      PH_HEIGHT: return 8;
      PH_VERSION: return 2;
      PH_HASH, PH_ROOT, PH_SIG: return HASH_LEN;
      default: return 4;
    endcase
  endfunction

  task automatic clear_parse();
    parse_ph = PH_MAGIC;
    field_pos = '0;
    num_acc = '0;
    sigs_left = '0;
    id_left = '0;
    latched_err = ST_BUSY;
  endtask

  task automatic latch_error(input status_e code);
    latched_err = code;
    parse_ph = PH_DISCARD;
  endtask

  task automatic classify_byte(input logic [7:0] b, input logic eor);
    classified_t r;
    logic fin;
    r = '0;
    r.kind = PH_DISCARD;
    r.data = b;
    r.done = eor;
    r.status = ST_BUSY;
    if (parse_ph == PH_DONE) begin
      latch_error(ST_TRAILING);
    end else if (parse_ph != PH_DISCARD) begin
      r.kind = parse_ph;
      r.pos = field_pos[15:0];
      if (carries_number(parse_ph))
        num_acc = num_acc | (64'(b) << (8 * field_pos[2:0]));
      field_pos = field_pos + 1;
      if (parse_ph == PH_ID) begin
        id_left = id_left - 1;
        fin = (id_left == 0);
      end else begin
        fin = (field_pos >= field_len(parse_ph));
      end
      if (fin) begin
        if (carries_number(parse_ph)) begin
          r.nv = 1'b1;
          r.value = num_acc;
        end
        field_pos = '0;
        num_acc = '0;
        case (parse_ph)
          PH_MAGIC: begin
            if (r.value != 64'(CKPT_MAGIC)) latch_error(ST_BAD_MAGIC);
            else parse_ph = PH_FORMAT;
          end
          PH_FORMAT: begin
            if (r.value != 64'(CKPT_FORMAT)) latch_error(ST_BAD_FORMAT);
            else parse_ph = PH_HEIGHT;
          end
          PH_HEIGHT: parse_ph = PH_HASH;
          PH_HASH: parse_ph = PH_ROOT;
          PH_ROOT: parse_ph = PH_VERSION;
          PH_VERSION: parse_ph = PH_COUNT;
          PH_COUNT: begin
            sigs_left = r.value[31:0];
            parse_ph = (sigs_left != 0) ? PH_IDLEN : PH_DONE;
          end
          PH_IDLEN: begin
            if (r.value > 64'(id_limit)) begin
              latch_error(ST_ID_LONG);
            end else begin
              id_left = r.value[31:0];
              parse_ph = (id_left != 0) ? PH_ID : PH_SIG;
            end
          end
          PH_ID: parse_ph = PH_SIG;
          default: begin
            sigs_left = sigs_left - 1;
            parse_ph = (sigs_left != 0) ? PH_IDLEN : PH_DONE;
          end
        endcase
      end
    end
    if (latched_err != ST_BUSY) r.status = latched_err;
    else if (eor) r.status = (parse_ph == PH_DONE) ? ST_OK : ST_TRUNC;
    if (eor) clear_parse();
    classified_q = {classified_q, r};
  endtask

  task automatic fill_bytes(ref logic [7:0] rec[$], input int unsigned n, input fill_e fill);
    repeat (n) begin
      if (fill == FILL_ZERO) rec = {rec, 8'h00};
      else if (fill == FILL_ONES) rec = {rec, 8'hFF};
      else rec = {rec, 8'($urandom)};
    end
  endtask

  task automatic put_le(ref logic [7:0] rec[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) rec = {rec, v[8*i +: 8]};
  endtask

  task automatic queue_record(input rec_shape_e shape, input int unsigned nsig,
                              input int unsigned id_lo, input int unsigned id_hi,
                              input fill_e fill);
    logic [7:0]   rec[$];
    logic [31:0]  magic;
    logic [31:0]  fmt;
    logic [31:0]  cnt;
    logic [31:0]  idlen;
    int unsigned  bad_sig;
    int unsigned  cut;
    stream_byte_t sb;
    magic = CKPT_MAGIC;
    fmt = CKPT_FORMAT;
    cnt = nsig;
    bad_sig = nsig;
    if (shape == SHAPE_BAD_MAGIC) magic = magic ^ (32'd1 << $urandom_range(31));
    if (shape == SHAPE_BAD_FORMAT) fmt = fmt ^ (32'd1 << $urandom_range(31));
    if (shape == SHAPE_ID_LONG) bad_sig = $urandom_range(nsig - 1);
    if (shape == SHAPE_TRUNC && $urandom_range(3) == 0) cnt = $urandom;
    if (shape == SHAPE_NOISE) begin
      fill_bytes(rec, $urandom_range(12, 1), FILL_RAND);
    end else begin
      put_le(rec, magic);
      put_le(rec, fmt);
      fill_bytes(rec, 8, fill);
      fill_bytes(rec, 2 * HASH_LEN, fill);
      fill_bytes(rec, 2, fill);
      put_le(rec, cnt);
      for (int s = 0; s < nsig; s++) begin
        if (s == bad_sig) begin
          if (id_limit == 16'hFFFF || $urandom_range(1) == 1)
            idlen = $urandom_range(32'hFFFF_FFFF, 32'(id_limit) + 1);
          else
            idlen = 32'(id_limit) + 1;
          put_le(rec, idlen);
          fill_bytes(rec, $urandom_range(3), FILL_RAND);
          break;
        end
        idlen = $urandom_range(id_hi, id_lo);
        put_le(rec, idlen);
        fill_bytes(rec, idlen, fill);
        fill_bytes(rec, HASH_LEN, fill);
      end
      if (shape == SHAPE_TRAIL) fill_bytes(rec, $urandom_range(4, 1), FILL_RAND);
      if (shape == SHAPE_TRUNC) begin
        cut = $urandom_range(rec.size() - 1, 1);
        while (rec.size() > cut) void'(rec.pop_back());
      end
    end
    foreach (rec[i]) begin
      sb.data = rec[i];
      sb.eor = (i == rec.size() - 1);
      record_bytes_q = {record_bytes_q, sb};
    end
    bytes_queued += rec.size();
  endtask

  task automatic queue_random_record();
    int unsigned pick;
    int unsigned nsig;
    int unsigned top;
    rec_shape_e  shape;
    pick = $urandom_range(99);
    if (pick < 55) shape = SHAPE_GOOD;
    else if (pick < 67) shape = SHAPE_TRUNC;
    else if (pick < 75) shape = SHAPE_TRAIL;
    else if (pick < 81) shape = SHAPE_BAD_MAGIC;
    else if (pick < 87) shape = SHAPE_BAD_FORMAT;
    else if (pick < 94) shape = SHAPE_ID_LONG;
    else shape = SHAPE_NOISE;
    nsig = $urandom_range(3);
    if (shape == SHAPE_ID_LONG && nsig == 0) nsig = 1;
    top = ($urandom_range(7) == 0) ? 40 : 8;
    if (top > 32'(id_limit)) top = 32'(id_limit);
    queue_record(shape, nsig, 0, top, FILL_RAND);
  endtask

  task automatic write_id_limit(input logic [15:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.max_id_length <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    id_limit = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (record_bytes_q.size() != 0 || in_if.valid || classified_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (in_taken || !in_if.valid)) begin
      if (record_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = record_bytes_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.data_byte <= next_byte.data;
        in_if.end_of_record <= next_byte.eor;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_if.ready <= 1'b0;
      stall_hold--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accept, predict and check
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      report_error("timeout", 64'(cycle_count), 64'(CYCLE_LIMIT));
      $display("== FAIL ==");
      $finish;
    end else begin
      in_taken = (in_if.valid === 1'b1) && (in_if.ready === 1'b1);
      if (in_taken) classify_byte(in_if.data_byte, in_if.end_of_record);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (classified_q.size() == 0) begin
          report_error("unexpected result", 64'(out_if.byte_out), 64'd0);
        end else begin
          want = classified_q.pop_front();
          if (out_if.field_kind !== 4'(want.kind))
            report_error("field_kind", 64'(out_if.field_kind), 64'(want.kind));
          if (out_if.field_position !== want.pos)
            report_error("field_position", 64'(out_if.field_position), 64'(want.pos));
          if (out_if.byte_out !== want.data)
            report_error("byte_out", 64'(out_if.byte_out), 64'(want.data));
          if (out_if.number_value !== want.value)
            report_error("number_value", out_if.number_value, want.value);
          if (out_if.number_valid !== want.nv)
            report_error("number_valid", 64'(out_if.number_valid), 64'(want.nv));
          if (out_if.parse_status !== 3'(want.status))
            report_error("parse_status", 64'(out_if.parse_status), 64'(want.status));
          if (out_if.record_done !== want.done)
            report_error("record_done", 64'(out_if.record_done), 64'(want.done));
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_record = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_id_length = '0;
    out_if.ready = 1'b0;
    in_taken = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    bytes_queued = 0;
    stall_hold = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    id_limit = MAX_ID_RESET;
    clear_parse();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed records at the reset limit
    queue_record(SHAPE_GOOD, 0, 0, 0, FILL_ZERO);
    queue_record(SHAPE_GOOD, 1, 0, 0, FILL_ONES);
    queue_record(SHAPE_GOOD, 2, 1, 6, FILL_RAND);
    queue_record(SHAPE_GOOD, 1, 260, 260, FILL_RAND);
    queue_record(SHAPE_BAD_MAGIC, 1, 0, 4, FILL_RAND);
    queue_record(SHAPE_BAD_FORMAT, 1, 0, 4, FILL_RAND);
    queue_record(SHAPE_ID_LONG, 1, 0, 4, FILL_RAND);
    queue_record(SHAPE_ID_LONG, 3, 0, 4, FILL_ONES);
    queue_record(SHAPE_TRAIL, 0, 0, 0, FILL_RAND);
    queue_record(SHAPE_TRAIL, 2, 0, 4, FILL_RAND);
    repeat (2) queue_record(SHAPE_TRUNC, 2, 0, 4, FILL_RAND);
    repeat (2) queue_record(SHAPE_NOISE, 0, 0, 0, FILL_RAND);
    settle();

    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_id_limit(16'hFFFF);
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct = 0;
          write_id_limit(16'd0);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 46;
          write_id_limit(16'($urandom_range(65534, 1)));
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
          write_id_limit(16'd5);
        end
      endcase
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) queue_random_record();
      if (stage == 0) begin
        // long output hold-off while requests keep coming
        repeat (20) @(posedge clk_i);
        stall_hold = 300;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
